[design/flash_eeprom_emulation_wear_level_unit_defines.svh]
// Assertion macros shared by the wear-leveling EEPROM emulation design.
`ifndef FLASH_EEPROM_EMULATION_WEAR_LEVEL_UNIT_DEFINES_SVH
`define FLASH_EEPROM_EMULATION_WEAR_LEVEL_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FEWL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define FEWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

[design/fewl_pkg.sv]
// Shared types and codes for the wear-leveling EEPROM emulation unit.
package fewl_pkg;

  localparam int ADDR_W = 18;

  localparam logic [1:0] OP_SCAN  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  localparam logic [2:0] KIND_ACK   = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_LOAD  = 3'd2;
  localparam logic [2:0] KIND_FRESH = 3'd3;
  localparam logic [2:0] KIND_PAGE  = 3'd4;

  localparam logic [7:0] TAG_ERASED = 8'hFF;

  typedef enum logic [2:0] {
    CMD_SCAN,
    CMD_LOAD,
    CMD_READ,
    CMD_WRITE,
    CMD_COMMIT
  } cmd_t;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    cmd_t       cmd;
    logic       hit;
    logic [5:0] offset;
    logic [7:0] data;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_COMMIT,
    ST_STREAM
  } state_t;

endpackage

[design/fewl_front.sv]
// Front end: accepts items and classifies them into back-end commands.
module fewl_front #(
  parameter int PAGE_BYTES = 64
) (
  input  logic             start,
  input  logic             busy,
  input  logic [1:0]       in_op,
  input  logic [5:0]       in_offset,
  input  logic [7:0]       in_data,
  input  logic             in_last,
  output logic             push,
  output fewl_pkg::entry_t entry
);

  logic [8:0] off_ext;
  logic       below_page;
  logic       below_tag;

  assign off_ext    = {3'b000, in_offset};
  assign below_page = off_ext < 9'(PAGE_BYTES);
  assign below_tag  = off_ext < 9'(PAGE_BYTES - 1);
  assign push       = start & ~busy;

  always_comb begin
    entry.offset = in_offset;
    entry.data   = in_data;
    entry.hit    = 1'b0;
    entry.cmd    = fewl_pkg::CMD_SCAN;
    unique case (in_op)
      fewl_pkg::OP_SCAN: begin
        entry.cmd = fewl_pkg::CMD_SCAN;
      end
      fewl_pkg::OP_LOAD: begin
        entry.cmd = fewl_pkg::CMD_LOAD;
        entry.hit = below_page;
      end
      fewl_pkg::OP_READ: begin
        entry.cmd = fewl_pkg::CMD_READ;
        entry.hit = below_tag;
      end
      fewl_pkg::OP_WRITE: begin
        entry.cmd = in_last ? fewl_pkg::CMD_COMMIT : fewl_pkg::CMD_WRITE;
        entry.hit = below_tag;
      end
      default: begin
        entry.cmd = fewl_pkg::CMD_SCAN;
      end
    endcase
  end

endmodule

[design/fewl_queue.sv]
// Two-entry command queue between the front end and the back end.
module fewl_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fewl_pkg::entry_t push_entry,
  input  logic             pop,
  output fewl_pkg::entry_t pop_entry,
  output logic             empty,
  output logic             full
);

  fewl_pkg::entry_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign empty     = count_r == 2'd0;
  assign full      = count_r == 2'd2;
  assign pop_entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[design/fewl_back.sv]
// Back end: scan tracking, page cache, commit sequencing and result output.
`include "flash_eeprom_emulation_wear_level_unit_defines.svh"

module fewl_back #(
  parameter int PAGE_BYTES    = 64,
  parameter int PAGES_PER_ROW = 4,
  parameter int ROWS          = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fewl_pkg::ADDR_W-1:0] base_addr,
  input  fewl_pkg::entry_t            cmd_entry,
  input  logic                        cmd_empty,
  output logic                        cmd_pop,
  output logic                        out_valid,
  output logic [2:0]                  out_kind,
  output logic [7:0]                  out_data_res,
  output logic [fewl_pkg::ADDR_W-1:0] out_flash_address,
  output logic                        out_erase_row,
  output logic [fewl_pkg::ADDR_W-1:0] out_erase_address,
  output logic                        out_final_res
);

  localparam int CW        = $clog2(PAGE_BYTES);
  localparam int RW        = $clog2(ROWS);
  localparam int PW        = (PAGES_PER_ROW > 1) ? $clog2(PAGES_PER_ROW) : 1;
  localparam int ROW_BYTES = PAGES_PER_ROW * PAGE_BYTES;

  function automatic logic [fewl_pkg::ADDR_W-1:0] page_addr(
    input logic [fewl_pkg::ADDR_W-1:0] base,
    input logic [RW-1:0]               row,
    input logic [PW-1:0]               page
  );
    logic [31:0] sum;
    sum = 32'(base) + 32'(row) * 32'(ROW_BYTES) + 32'(page) * 32'(PAGE_BYTES);
    return sum[fewl_pkg::ADDR_W-1:0];
  endfunction

  logic [7:0] cache_mem [PAGE_BYTES];

  fewl_pkg::state_t state_r, state_nxt;
  logic [7:0]    gen_r, gen_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [RW-1:0] scan_row_r, scan_row_nxt;
  logic [PW-1:0] scan_page_r, scan_page_nxt;
  logic          scan_done_r, scan_done_nxt;
  logic          erase_pend_r, erase_pend_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          res_vld_r, res_vld_nxt;
  logic [2:0]    res_kind_r, res_kind_nxt;
  logic          res_mem_r, res_mem_nxt;
  logic          res_addr_r, res_addr_nxt;
  logic          res_erase_r, res_erase_nxt;
  logic          res_final_r, res_final_nxt;
  logic [7:0]    rd_data_r;

  logic          mem_we;
  logic [CW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [CW-1:0] mem_raddr;

  logic [8:0]    off_ext;
  logic [CW-1:0] cmd_addr;
  logic [7:0]    tag_diff;
  logic [7:0]    gen_inc;
  logic          cnt_last;

  assign off_ext  = {3'b000, cmd_entry.offset};
  assign cmd_addr = off_ext[CW-1:0];
  assign tag_diff = cmd_entry.data - gen_r;
  assign gen_inc  = gen_r + 8'd1;
  assign cnt_last = cnt_r == CW'(PAGE_BYTES - 1);

  always_comb begin
    state_nxt      = state_r;
    gen_nxt        = gen_r;
    row_nxt        = row_r;
    page_nxt       = page_r;
    scan_row_nxt   = scan_row_r;
    scan_page_nxt  = scan_page_r;
    scan_done_nxt  = scan_done_r;
    erase_pend_nxt = erase_pend_r;
    cnt_nxt        = cnt_r;
    res_vld_nxt    = 1'b0;
    res_kind_nxt   = fewl_pkg::KIND_ACK;
    res_mem_nxt    = 1'b0;
    res_addr_nxt   = 1'b0;
    res_erase_nxt  = 1'b0;
    res_final_nxt  = 1'b1;
    mem_we         = 1'b0;
    mem_waddr      = cmd_addr;
    mem_wdata      = cmd_entry.data;
    mem_re         = 1'b0;
    mem_raddr      = cmd_addr;
    cmd_pop        = 1'b0;
    unique case (state_r)
      fewl_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          unique case (cmd_entry.cmd)
            fewl_pkg::CMD_SCAN: begin
              res_vld_nxt = 1'b1;
              if (scan_done_r) begin
                res_kind_nxt = fewl_pkg::KIND_ACK;
              end else if (cmd_entry.data == fewl_pkg::TAG_ERASED) begin
                scan_done_nxt = 1'b1;
                if (gen_r == fewl_pkg::TAG_ERASED) begin
                  // Empty region: start fresh at the last page so the first
                  // commit wraps to the start of the region.
                  row_nxt      = RW'(ROWS - 1);
                  page_nxt     = PW'(PAGES_PER_ROW - 1);
                  res_kind_nxt = fewl_pkg::KIND_FRESH;
                  cnt_nxt      = '0;
                  state_nxt    = fewl_pkg::ST_FILL;
                end else begin
                  res_kind_nxt = fewl_pkg::KIND_LOAD;
                  res_addr_nxt = 1'b1;
                end
              end else begin
                if (gen_r == fewl_pkg::TAG_ERASED || !tag_diff[7]) begin
                  gen_nxt  = cmd_entry.data;
                  row_nxt  = scan_row_r;
                  page_nxt = scan_page_r;
                end
                if (scan_row_r == RW'(ROWS - 1) &&
                    scan_page_r == PW'(PAGES_PER_ROW - 1)) begin
                  scan_done_nxt = 1'b1;
                  res_kind_nxt  = fewl_pkg::KIND_LOAD;
                  res_addr_nxt  = 1'b1;
                end else begin
                  res_kind_nxt = fewl_pkg::KIND_ACK;
                  if (scan_page_r == PW'(PAGES_PER_ROW - 1)) begin
                    scan_page_nxt = '0;
                    scan_row_nxt  = scan_row_r + RW'(1);
                  end else begin
                    scan_page_nxt = scan_page_r + PW'(1);
                  end
                end
              end
            end
            fewl_pkg::CMD_LOAD, fewl_pkg::CMD_WRITE: begin
              mem_we      = cmd_entry.hit;
              res_vld_nxt = 1'b1;
            end
            fewl_pkg::CMD_READ: begin
              mem_re       = 1'b1;
              res_vld_nxt  = 1'b1;
              res_kind_nxt = fewl_pkg::KIND_READ;
              res_mem_nxt  = cmd_entry.hit;
            end
            fewl_pkg::CMD_COMMIT: begin
              mem_we    = cmd_entry.hit;
              state_nxt = fewl_pkg::ST_COMMIT;
            end
            default: begin
              res_vld_nxt = 1'b0;
            end
          endcase
        end
      end
      fewl_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = cnt_last ? 8'h00 : 8'hFF;
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_last) begin
          state_nxt = fewl_pkg::ST_IDLE;
        end
      end
      fewl_pkg::ST_COMMIT: begin
        cnt_nxt   = '0;
        state_nxt = fewl_pkg::ST_STREAM;
        if (page_r == PW'(PAGES_PER_ROW - 1)) begin
          page_nxt       = '0;
          erase_pend_nxt = 1'b1;
          if (row_r == RW'(ROWS - 1)) begin
            // Whole region wrapped: bump the generation, skipping the erased code.
            row_nxt   = '0;
            gen_nxt   = (gen_inc == fewl_pkg::TAG_ERASED) ? 8'h00 : gen_inc;
            mem_we    = 1'b1;
            mem_waddr = CW'(PAGE_BYTES - 1);
            mem_wdata = (gen_inc == fewl_pkg::TAG_ERASED) ? 8'h00 : gen_inc;
          end else begin
            row_nxt = row_r + RW'(1);
          end
        end else begin
          page_nxt       = page_r + PW'(1);
          erase_pend_nxt = 1'b0;
        end
      end
      fewl_pkg::ST_STREAM: begin
        mem_re        = 1'b1;
        mem_raddr     = cnt_r;
        res_vld_nxt   = 1'b1;
        res_kind_nxt  = fewl_pkg::KIND_PAGE;
        res_mem_nxt   = 1'b1;
        res_addr_nxt  = 1'b1;
        res_erase_nxt = erase_pend_r && cnt_r == '0;
        res_final_nxt = cnt_last;
        cnt_nxt       = cnt_r + CW'(1);
        if (cnt_last) begin
          state_nxt = fewl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fewl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fewl_pkg::ST_IDLE;
      gen_r        <= fewl_pkg::TAG_ERASED;
      row_r        <= '0;
      page_r       <= '0;
      scan_row_r   <= '0;
      scan_page_r  <= '0;
      scan_done_r  <= 1'b0;
      erase_pend_r <= 1'b0;
      cnt_r        <= '0;
      res_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      gen_r        <= gen_nxt;
      row_r        <= row_nxt;
      page_r       <= page_nxt;
      scan_row_r   <= scan_row_nxt;
      scan_page_r  <= scan_page_nxt;
      scan_done_r  <= scan_done_nxt;
      erase_pend_r <= erase_pend_nxt;
      cnt_r        <= cnt_nxt;
      res_vld_r    <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_kind_r  <= res_kind_nxt;
    res_mem_r   <= res_mem_nxt;
    res_addr_r  <= res_addr_nxt;
    res_erase_r <= res_erase_nxt;
    res_final_r <= res_final_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cache_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= cache_mem[mem_raddr];
    end
  end

  // Row and page stay put while a beat that needs their address is on the outputs.
  assign out_valid         = res_vld_r;
  assign out_kind          = res_kind_r;
  assign out_data_res      = res_mem_r ? rd_data_r : 8'h00;
  assign out_flash_address = res_addr_r ? page_addr(base_addr, row_r, page_r) : '0;
  assign out_erase_row     = res_erase_r;
  assign out_erase_address = res_erase_r ? page_addr(base_addr, row_r, PW'(0)) : '0;
  assign out_final_res     = res_final_r;

  `FEWL_ASSERT_NEXT(a_stream_ends, clk, rst_n, state_r == fewl_pkg::ST_STREAM && cnt_last, state_r == fewl_pkg::ST_IDLE)
  `FEWL_ASSERT_NEXT(a_stream_contiguous, clk, rst_n, res_vld_r && res_kind_r == fewl_pkg::KIND_PAGE && !res_final_r, res_vld_r && res_kind_r == fewl_pkg::KIND_PAGE)
  `FEWL_ASSERT_NOW(a_fresh_fills, clk, rst_n, res_vld_r && res_kind_r == fewl_pkg::KIND_FRESH, state_r == fewl_pkg::ST_FILL)

endmodule

[design/flash_eeprom_emulation_wear_level_unit.sv]
// Accepted items pass through the command queue and their result beats are registered.
// A commit's 64 page beats (PAGE_BYTES in general) follow its commit step, one per cycle.
// Scan, load, read and plain write: one item per cycle while busy is low; a commit holds the
// back end through its commit step and page stream, and a fresh start through its cache fill.
// busy rises when the two-entry command queue is full. Results cannot be stalled.
// Reset (synchronous, rst_n low) clears scan state and queue; the page cache is not cleared.
module flash_eeprom_emulation_wear_level_unit #(
  parameter int PAGE_BYTES    = 64,
  parameter int PAGES_PER_ROW = 4,
  parameter int ROWS          = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic [5:0]                  in_offset,
  input  logic [7:0]                  in_data,
  input  logic                        in_last,
  output logic                        out_valid,
  output logic [2:0]                  out_kind,
  output logic [7:0]                  out_data_res,
  output logic [fewl_pkg::ADDR_W-1:0] out_flash_address,
  output logic                        out_erase_row,
  output logic [fewl_pkg::ADDR_W-1:0] out_erase_address,
  output logic                        out_final_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [fewl_pkg::ADDR_W-1:0] cfg_base_r;
  logic                        cfg_wr;

  logic             push;
  fewl_pkg::entry_t push_entry;
  fewl_pkg::entry_t pop_entry;
  logic             pop;
  logic             q_empty;
  logic             q_full;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & ~paddr[2];
  assign prdata = paddr[2] ? 32'h0 : 32'(cfg_base_r);
  assign busy   = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r <= 18'd261120;
    end else if (cfg_wr) begin
      cfg_base_r <= pwdata[fewl_pkg::ADDR_W-1:0];
    end
  end

  fewl_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .start    (start),
    .busy     (busy),
    .in_op    (in_op),
    .in_offset(in_offset),
    .in_data  (in_data),
    .in_last  (in_last),
    .push     (push),
    .entry    (push_entry)
  );

  fewl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .pop_entry (pop_entry),
    .empty     (q_empty),
    .full      (q_full)
  );

  fewl_back #(
    .PAGE_BYTES   (PAGE_BYTES),
    .PAGES_PER_ROW(PAGES_PER_ROW),
    .ROWS         (ROWS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .base_addr        (cfg_base_r),
    .cmd_entry        (pop_entry),
    .cmd_empty        (q_empty),
    .cmd_pop          (pop),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_data_res     (out_data_res),
    .out_flash_address(out_flash_address),
    .out_erase_row    (out_erase_row),
    .out_erase_address(out_erase_address),
    .out_final_res    (out_final_res)
  );

endmodule
